@@ hdl/t9ss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ss_pkg: shared types and constants of the keypad substring search
// Holds the symbol coding, the queue item layouts, the register indexes and
// the character-to-keypad mapping function.
// ----------------------------------------------------------------------------
package t9ss_pkg;

	localparam int unsigned WIN_DEPTH = 16;
	localparam int unsigned SYM_W     = 4;
	localparam int unsigned PAT_W     = 64;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned CHAR_W    = 8;

	localparam logic [SYM_W-1:0] SPACE_SYM = 4'd10;

	// register indexes of the configuration port
	localparam logic CFG_PATTERN = 1'b0;
	localparam logic CFG_LENGTH  = 1'b1;

	// queue depths between the parts
	localparam int unsigned MID_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 2;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} sym_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             matched;
		logic             done;
	} res_item_t;

	// Map one byte to its keypad symbol.
	function automatic logic [SYM_W-1:0] key_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] lc;
		logic [CHAR_W-1:0] l;
		logic [SYM_W-1:0]  k;
		lc = c | 8'h20;
		l  = lc - 8'h61;
		if (c inside {[8'h30:8'h39]}) begin
			k = c[3:0];
		end else if (c == 8'h2B) begin
			k = 4'd0;
		end else if (lc inside {[8'h61:8'h7A]}) begin
			if (l < 8'd3)       k = 4'd2;
			else if (l < 8'd6)  k = 4'd3;
			else if (l < 8'd9)  k = 4'd4;
			else if (l < 8'd12) k = 4'd5;
			else if (l < 8'd15) k = 4'd6;
			else if (l < 8'd19) k = 4'd7;
			else if (l < 8'd22) k = 4'd8;
			else                k = 4'd9;
		end else begin
			k = SPACE_SYM;
		end
		return k;
	endfunction

endpackage

@@ hdl/t9ss_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ss_fifo: small synchronous queue
// Register-based queue with a count; full and empty come from the count.
// ----------------------------------------------------------------------------
module t9ss_fifo #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/t9ss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ss_front: input stage of the keypad search
// Accepts one byte per cycle while full is low, maps it to its keypad symbol
// and holds it in a register stage until the middle queue takes it.
// ----------------------------------------------------------------------------
module t9ss_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           char_code,
	input  logic                 record_end,
	output logic                 item_valid,
	output t9ss_pkg::sym_item_t  item,
	input  logic                 item_ready
);

	import t9ss_pkg::*;

	logic      valid_s1;
	sym_item_t item_s1;
	logic      take;

	// stall only while the stage holds an item that cannot move on
	assign full       = valid_s1 && !item_ready;
	assign take       = push && !full;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.symbol <= key_of(char_code);
			item_s1.last   <= record_end;
		end
	end

endmodule

@@ hdl/t9ss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9ss_back: symbol window and pattern match
// Holds the pattern registers, shifts symbols into the window, compares the
// newest symbols against the pattern and keeps the sticky per-record flag.
// ----------------------------------------------------------------------------
module t9ss_back #(
	parameter int unsigned PATTERN_MAX = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_addr,
	input  logic [t9ss_pkg::PAT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  t9ss_pkg::sym_item_t           in_item,
	output logic                          in_take,
	input  logic                          out_ready,
	output logic                          out_push,
	output t9ss_pkg::res_item_t           out_item
);

	import t9ss_pkg::*;

	localparam logic [LEN_W-1:0] PAT_MAX_C = LEN_W'(PATTERN_MAX);
	localparam logic [LEN_W-1:0] WIN_FULL  = LEN_W'(WIN_DEPTH);

	logic [PAT_W-1:0] pattern_q;
	logic [LEN_W-1:0] length_q;
	logic [SYM_W-1:0] win_q    [WIN_DEPTH];
	logic [SYM_W-1:0] win_next [WIN_DEPTH];
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] fill_next;
	logic             match_q;
	logic [LEN_W-1:0] len_eff;
	logic [WIN_DEPTH-1:0] tap_ok;
	logic             hit;
	logic             step;

	assign step     = in_valid && out_ready;
	assign in_take  = step;
	assign out_push = step;

	assign len_eff   = (length_q > PAT_MAX_C) ? PAT_MAX_C : length_q;
	assign fill_next = (fill_q < WIN_FULL) ? fill_q + 1'b1 : fill_q;

	always_comb begin
		win_next[0] = in_item.symbol;
		for (int j = 1; j < WIN_DEPTH; j++) begin
			win_next[j] = win_q[j-1];
		end
	end

	// tap j holds the symbol that lines up with pattern entry len-1-j
	always_comb begin : p_taps
		logic [LEN_W-1:0] pos;
		logic [SYM_W-1:0] want;
		for (int j = 0; j < WIN_DEPTH; j++) begin
			pos       = len_eff - LEN_W'(j) - 1'b1;
			want      = pattern_q[{pos[3:0], 2'b00} +: SYM_W];
			tap_ok[j] = (LEN_W'(j) >= len_eff) || (win_next[j] == want);
		end
	end

	assign hit = (len_eff == '0) || ((fill_next >= len_eff) && (&tap_ok));

	assign out_item.symbol  = in_item.symbol;
	assign out_item.matched = match_q || hit;
	assign out_item.done    = in_item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= '0;
		end else if (cfg_write) begin
			if (cfg_addr == CFG_PATTERN) begin
				pattern_q <= cfg_data;
			end
			if (cfg_addr == CFG_LENGTH) begin
				length_q <= cfg_data[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			match_q <= 1'b0;
		end else if (step) begin
			if (in_item.last) begin
				fill_q  <= '0;
				match_q <= 1'b0;
			end else begin
				fill_q  <= fill_next;
				match_q <= match_q || hit;
			end
		end
	end

	// window entries past the fill count never decide a match
	always_ff @(posedge clk) begin
		if (step) begin
			for (int j = 0; j < WIN_DEPTH; j++) begin
				win_q[j] <= win_next[j];
			end
		end
	end

`ifndef ASSERT_OFF
	a_empty_pattern_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && (len_eff == '0) |-> out_item.matched)
		else $error("empty pattern did not match");

	a_record_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_item.done |=> (fill_q == '0) && !match_q)
		else $error("record state not cleared after last character");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_FULL)
		else $error("window fill beyond window depth");

	a_match_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_item.matched && !out_item.done |=> match_q)
		else $error("match flag lost within a record");

	a_no_match_short_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && (len_eff != '0) && (fill_next < len_eff) |-> out_item.matched == match_q)
		else $error("match raised before enough symbols arrived");
`endif

endmodule

@@ hdl/t9_substring_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9_substring_search: keypad substring search over contact records
// Maps each byte to a keypad symbol and flags records that hold the pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive char_code and record_end with push; the
//   transaction completes on a rising edge with push high and full low.
//   Mark the last byte of each record with record_end.
//   Result side is a queue: while empty is low, mapped_symbol,
//   record_matches and record_done describe the oldest result; a
//   transaction completes on a rising edge with pop high and empty low.
//   Exactly one result per input byte, in order. record_matches is final
//   for the record when record_done is set.
//   Path: input stage register, middle queue, window compare, output queue.
//   Throughput: one byte per cycle unless stalled; the compare is combinational.
//   When the receiver stalls, the output queue fills, then the middle
//   queue, then the input stage raises full; nothing is dropped.
//   Reset clears the queues, the record state and both pattern registers.
//   Write cfg_data to register cfg_addr (0 pattern symbols, 1 pattern
//   length) with cfg_write, only while no transaction is in flight.
// ----------------------------------------------------------------------------
module t9_substring_search #(
	parameter int unsigned PATTERN_MAX = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_addr,
	input  logic [t9ss_pkg::PAT_W-1:0]  cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  char_code,
	input  logic                        record_end,
	output logic                        empty,
	input  logic                        pop,
	output logic [3:0]                  mapped_symbol,
	output logic                        record_matches,
	output logic                        record_done
);

	import t9ss_pkg::*;

	localparam int unsigned MID_W = $bits(sym_item_t);
	localparam int unsigned RES_W = $bits(res_item_t);

	sym_item_t front_item;
	logic      front_valid;
	logic      mid_full;
	sym_item_t mid_item;
	logic      mid_empty;
	logic      back_take;
	logic      out_full;
	logic      back_push;
	res_item_t back_item;
	res_item_t res_item;

	// map bytes and hold them in the input stage
	t9ss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_code  (char_code),
		.record_end (record_end),
		.item_valid (front_valid),
		.item       (front_item),
		.item_ready (!mid_full)
	);

	// decouple the mapper from the matcher
	t9ss_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_item),
		.full    (mid_full),
		.rd_en   (back_take),
		.rd_data (mid_item),
		.empty   (mid_empty)
	);

	// advance the window and evaluate the pattern
	t9ss_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (!mid_empty),
		.in_item   (mid_item),
		.in_take   (back_take),
		.out_ready (!out_full),
		.out_push  (back_push),
		.out_item  (back_item)
	);

	// hold finished results until the receiver pops them
	t9ss_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_push),
		.wr_data (back_item),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (res_item),
		.empty   (empty)
	);

	assign mapped_symbol  = res_item.symbol;
	assign record_matches = res_item.matched;
	assign record_done    = res_item.done;

endmodule

@@ sim/t9_substring_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9_substring_search_tb: self-checking bench for the keypad substring search
// Streams contact bytes into the input queue with random gaps and drains the
// result queue with random stalls. A scoreboard tracks the symbol window and
// match flag of each record and checks every result field by field.
// ----------------------------------------------------------------------------
import t9ss_pkg::*;

class keypad_scoreboard;
	logic [PAT_W-1:0] pattern;
	logic [LEN_W-1:0] length;
	logic [SYM_W-1:0] window [WIN_DEPTH];
	int               fill;
	logic             seen;
	res_item_t        expected_q [$];
	int unsigned      mismatches;
	int unsigned      records;
	int unsigned      matched_records;

	function new();
		clear_record();
		pattern = '0;
		length = '0;
		mismatches = 0;
		records = 0;
		matched_records = 0;
	endfunction

	function void clear_record();
		for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
		fill = 0;
		seen = 1'b0;
	endfunction

	// phone key of letter number idx (0 for a/A)
	static function logic [SYM_W-1:0] letter_key(input int idx);
		if (idx < 15) return 4'(2 + idx / 3);
		if (idx < 19) return 4'd7;
		if (idx < 22) return 4'd8;
		return 4'd9;
	endfunction

	static function logic [SYM_W-1:0] key_symbol(input logic [7:0] c);
		int idx;
		if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
		if (c == 8'h2B) return 4'd0;
		if (c >= 8'h41 && c <= 8'h5A) idx = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A) idx = c - 8'h61;
		else return SPACE_SYM;
		return letter_key(idx);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Shift the byte's symbol into the window, update the sticky flag and
	// queue the result the block owes for it.
	function void note_input(input logic [7:0] c, input logic last);
		res_item_t exp_item;
		int        span;
		logic      hit;
		for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
		window[0] = key_symbol(c);
		if (fill < WIN_DEPTH) fill++;
		// lengths above the window depth clamp to a full window
		span = (length > WIN_DEPTH) ? WIN_DEPTH : length;
		hit = (fill >= span);
		for (int i = 0; i < span; i++)
			if (window[span - 1 - i] != pattern[4 * i +: 4]) hit = 1'b0;
		if (hit) seen = 1'b1;
		exp_item.symbol = window[0];
		exp_item.matched = seen;
		exp_item.done = last;
		expected_q.push_back(exp_item);
		if (last) clear_record();
	endfunction

	task report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task check_result(input logic [SYM_W-1:0] sym, input logic m, input logic d);
		res_item_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result symbol=%0d match=%0b done=%0b",
				sym, m, d));
			return;
		end
		want = expected_q.pop_front();
		if (sym !== want.symbol)
			report_mismatch($sformatf("mapped_symbol %0d, want %0d", sym, want.symbol));
		if (m !== want.matched)
			report_mismatch($sformatf("record_matches %0b, want %0b", m, want.matched));
		if (d !== want.done)
			report_mismatch($sformatf("record_done %0b, want %0b", d, want.done));
		if (want.done) begin
			records++;
			if (want.matched) matched_records++;
		end
	endtask
endclass

module t9_substring_search_tb;

	localparam int unsigned STALL_PCT      = 21;
	localparam int unsigned RANDOM_ITEMS   = 1450;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             cfg_write  = 1'b0;
	logic             cfg_addr   = CFG_PATTERN;
	logic [PAT_W-1:0] cfg_data   = '0;
	logic             push       = 1'b0;
	logic [7:0]       char_code  = '0;
	logic             record_end = 1'b0;
	logic             pop        = 1'b0;
	logic             full;
	logic             empty;
	logic [3:0]       mapped_symbol;
	logic             record_matches;
	logic             record_done;

	keypad_scoreboard sb = new();

	// high while both sides run flat out, no idling
	bit          steady        = 1'b0;
	int unsigned bytes_sent    = 0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles  = 0;

	t9_substring_search u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.char_code      (char_code),
		.record_end     (record_end),
		.empty          (empty),
		.pop            (pop),
		.mapped_symbol  (mapped_symbol),
		.record_matches (record_matches),
		.record_done    (record_done)
	);

	always #1 clk = ~clk;

	// Result side: check each popped transaction against the oldest
	// expectation, then pick pop for the next edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_result(mapped_symbol, record_matches, record_done);
			pop <= steady || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	// Watchdog: end the run when no transaction moves on either side for
	// too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("t9_substring_search_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Push one byte. Idle first at random; push stays high after the
	// transaction so back-to-back bytes need no second assignment.
	task automatic send_char(input logic [7:0] c, input logic last);
		if (!steady) begin
			while ($urandom_range(0, 99) < STALL_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		char_code <= c;
		record_end <= last;
		do @(posedge clk); while (full);
		sb.note_input(c, last);
		bytes_sent++;
	endtask

	// Hold the input side until every expected result has been popped.
	task automatic drain_results();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write the pattern register, then the length register; call only when drained.
	task automatic program_pattern(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len);
		cfg_write <= 1'b1;
		cfg_addr <= CFG_PATTERN;
		cfg_data <= pat;
		@(posedge clk);
		cfg_addr <= CFG_LENGTH;
		cfg_data <= PAT_W'(len);
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.pattern = pat;
		sb.length = len;
		settings_used++;
	endtask

	// Pick a byte that maps to the given symbol; unused codes get any byte.
	function automatic logic [7:0] char_for_symbol(input logic [SYM_W-1:0] sym);
		logic [7:0] c;
		int         idx;
		if (sym > SPACE_SYM) return 8'($urandom_range(0, 255));
		if (sym == SPACE_SYM) begin
			do c = 8'($urandom_range(0, 255));
			while (sb.key_symbol(c) != SPACE_SYM);
			return c;
		end
		if (sym == 4'd0) return $urandom_range(0, 1) ? 8'h2B : 8'h30;
		if (sym == 4'd1 || $urandom_range(0, 1)) return 8'h30 + 8'(sym);
		do idx = $urandom_range(0, 25);
		while (sb.letter_key(idx) != sym);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(idx);
	endfunction

	// Filler text: letters, digits, separators and the odd raw byte.
	function automatic logic [7:0] filler_char();
		case ($urandom_range(0, 3))
			0: return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
			1: return 8'h30 + 8'($urandom_range(0, 9));
			2: return $urandom_range(0, 1) ? 8'h20 : 8'h2B;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One record: mostly the whole pattern inside filler, some cut short
	// after a random part of it, the rest plain noise.
	task automatic send_record();
		logic [7:0] text [$];
		int         span;
		int         mode;
		int         cut;
		int         mid;
		span = (sb.length > WIN_DEPTH) ? WIN_DEPTH : sb.length;
		mode = $urandom_range(0, 99);
		repeat ($urandom_range(0, 8)) text.push_back(filler_char());
		if (mode < 55 && span > 0) begin
			for (int i = 0; i < span; i++)
				text.push_back(char_for_symbol(sb.pattern[4 * i +: 4]));
		end else if (mode < 75 && span > 1) begin
			cut = $urandom_range(1, span - 1);
			for (int i = 0; i < cut; i++)
				text.push_back(char_for_symbol(sb.pattern[4 * i +: 4]));
			text.push_back(filler_char());
		end else begin
			repeat ($urandom_range(1, 24)) text.push_back(filler_char());
		end
		repeat ($urandom_range(0, 8)) text.push_back(filler_char());
		// now and then drain in the middle of a record
		mid = ($urandom_range(0, 29) == 0) ? $urandom_range(0, text.size() - 1) : -1;
		foreach (text[i]) begin
			send_char(text[i], i == text.size() - 1);
			if (i == mid) drain_results();
		end
	endtask

	// Draw a setting: phase 0 empty pattern, phase 1 full length, then a
	// mix weighted toward short patterns so matches stay common.
	task automatic pick_setting(input int phase);
		logic [PAT_W-1:0] pat;
		logic [LEN_W-1:0] len;
		int               r;
		r = $urandom_range(0, 99);
		for (int i = 0; i < 16; i++)
			pat[4 * i +: 4] = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
		if ($urandom_range(0, 9) == 0) pat = {$urandom, $urandom};
		if (phase == 0 || r < 8) len = 5'd0;
		else if (phase == 1 || r < 16) len = 5'd16;
		else if (r < 24) len = 5'($urandom_range(17, 31));
		else if (r < 60) len = 5'($urandom_range(1, 3));
		else len = 5'($urandom_range(4, 15));
		program_pattern(pat, len);
	endtask

	initial begin
		string            tour;
		logic [PAT_W-1:0] tour_pat;
		int unsigned      random_start;
		int               phase;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: empty pattern, so every record matches. Zero byte,
		// top byte and '+'.
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h2B, 1'b1);
		drain_results();

		// Pattern "2 space 9": a record too short to match, then one that does.
		program_pattern(64'h9A2, 5'd3);
		send_char("a", 1'b0);
		send_char(" ", 1'b1);
		send_char("X", 1'b0);
		send_char("a", 1'b0);
		send_char(" ", 1'b0);
		send_char("z", 1'b1);
		drain_results();

		// Unused code in the pattern never matches; first non-ASCII byte.
		program_pattern(64'hB, 5'd1);
		send_char("1", 1'b0);
		send_char(8'h80, 1'b1);
		drain_results();

		// Length over the limit clamps to 16; the text walks the key
		// boundaries in both cases.
		tour = "opstvwZ+9jkLMgiD";
		for (int i = 0; i < 16; i++)
			tour_pat[4 * i +: 4] = sb.key_symbol(tour[i]);
		program_pattern(tour_pat, 5'd31);
		for (int i = 0; i < 16; i++) send_char(tour[i], i == 15);

		// Random phases; phase 2 runs both sides without idling.
		random_start = bytes_sent;
		phase = 0;
		while (bytes_sent - random_start < RANDOM_ITEMS) begin
			drain_results();
			pick_setting(phase);
			steady = (phase == 2);
			repeat (steady ? 30 : $urandom_range(3, 12)) send_record();
			phase++;
		end

		drain_results();
		steady = 1'b0;
		repeat (4) @(posedge clk);

		$display("Ran %0d bytes in %0d records across %0d pattern settings",
			bytes_sent, sb.records, settings_used);
		$display("Records with a match: %0d, without: %0d, mismatches: %0d",
			sb.matched_records, sb.records - sb.matched_records, sb.mismatches);
		if (sb.mismatches == 0) $display("t9_substring_search_tb passed");
		else $display("t9_substring_search_tb failed");
		$finish;
	end

endmodule

@@ t9_substring_search.f @@
hdl/t9ss_pkg.sv
hdl/t9ss_fifo.sv
hdl/t9ss_front.sv
hdl/t9ss_back.sv
hdl/t9_substring_search.sv
sim/t9_substring_search_tb.sv
